@@ rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, with and without a reset disable.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge, off while reset is high
`define STAP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define STAP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/stap_pkg.sv @@
// -----------------------------------------------------------------------------
// Tremolo / autopanner package
// Word types, register map, waveform codes, sequencer states and constants.
// -----------------------------------------------------------------------------
package stap_pkg;

   // fixed formats
   localparam int SAMPLE_BITS    = 24;
   localparam int PHASE_BITS_DEF = 32;
   localparam int SINE_DEPTH_DEF = 1024;
   localparam int MUL_W          = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // Q1.15 unity
   localparam logic [15:0] Q_ONE = 16'h8000;

   // quarter-wave sine polynomial coefficients, Q1.15
   localparam logic [15:0] POLY_A = 16'd51472;
   localparam logic [15:0] POLY_B = 16'd21024;
   localparam logic [15:0] POLY_C = 16'd2320;
   localparam logic [15:0] HALF_QUAD = 16'd16384;

   // register reset values
   localparam logic [23:0] RST_PHASE_STEP = 24'd178957;
   localparam logic [15:0] RST_MOD_DEPTH  = 16'd16384;
   localparam logic [2:0]  RST_WAVE_SHAPE = 3'd0;
   localparam logic [15:0] RST_OFFSET     = 16'd32768;
   localparam logic [15:0] RST_MIN_GAIN   = 16'd0;
   localparam logic [15:0] RST_WET_MIX    = 16'd32768;

   // register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_STEP   = 3'd0,
      REG_MOD_DEPTH    = 3'd1,
      REG_WAVE_SHAPE   = 3'd2,
      REG_RIGHT_OFFSET = 3'd3,
      REG_MIN_GAIN     = 3'd4,
      REG_WET_MIX      = 3'd5
   } reg_index_type;

   // waveform codes; unused codes fall back to sine
   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_SQUARE   = 3'd2,
      WAVE_SAW      = 3'd3,
      WAVE_RSAW     = 3'd4
   } wave_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_IDX,
      ST_QEST,
      ST_QMUL,
      ST_QFIX,
      ST_X2,
      ST_T,
      ST_A,
      ST_S,
      ST_LFO,
      ST_DL,
      ST_MG,
      ST_GW,
      ST_COEF,
      ST_MUL,
      ST_RND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic                          block_end_in;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic                          block_end_out;
   } rsp_word_type;

   // settings as the datapath uses them (Q1.15 values already clamped)
   typedef struct packed {
      logic [23:0] phase_step;
      logic [15:0] depth;
      logic [2:0]  shape;
      logic [15:0] phase_offset;
      logic [15:0] floor_gain;
      logic [15:0] mix;
   } cfg_type;

   // clamp a Q1.15 value to unity
   function automatic logic [15:0] sat_q(input logic [15:0] v);
      return (v > Q_ONE) ? Q_ONE : v;
   endfunction

endpackage

@@ rtl/stap_mul.sv @@
// -----------------------------------------------------------------------------
// Shared multiplier
// Signed MUL_W x MUL_W multiply with a registered product; every product of
// the block passes through here.
// -----------------------------------------------------------------------------
module stap_mul
   import stap_pkg::*;
(
   input  logic                        clock,
   input  logic signed [MUL_W-1:0]     op_a,
   input  logic signed [MUL_W-1:0]     op_b,
   output logic signed [2*MUL_W-1:0]   prod_ff
);

   logic signed [2*MUL_W-1:0] prod_in;

   // multiply
   always_comb begin
      prod_in = op_a * op_b;
   end

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/stap_wave.sv @@
// -----------------------------------------------------------------------------
// LFO waveform shaper
// Triangle, square and saw shapes from the top 16 phase bits; flags the sine
// shape, which the sequencer evaluates on the shared multiplier.
// -----------------------------------------------------------------------------
module stap_wave
   import stap_pkg::*;
(
   input  logic [2:0]  shape,
   input  logic [15:0] phase,
   output logic [15:0] lfo,
   output logic        is_sine
);

   logic [15:0] half_phase;

   assign half_phase = {1'b0, phase[15:1]};

   // shape select
   always_comb begin
      lfo     = '0;
      is_sine = 1'b0;
      case (shape)
         WAVE_TRIANGLE: begin
            lfo = phase[15] ? 16'(17'h10000 - 17'(phase)) : phase;
         end
         WAVE_SQUARE: begin
            lfo = phase[15] ? 16'd0 : Q_ONE;
         end
         WAVE_SAW: begin
            lfo = half_phase;
         end
         WAVE_RSAW: begin
            lfo = Q_ONE - half_phase;
         end
         default: begin
            is_sine = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/stap_csr.sv @@
// -----------------------------------------------------------------------------
// Settings registers
// Six write-only registers; Q1.15 settings are clamped to unity on the way out.
// -----------------------------------------------------------------------------
module stap_csr
   import stap_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   logic [23:0] phase_step_ff;
   logic [15:0] mod_depth_ff;
   logic [2:0]  wave_shape_ff;
   logic [15:0] offset_ff;
   logic [15:0] min_gain_ff;
   logic [15:0] wet_mix_ff;

   // writes land at once
   assign csr_ready = 1'b1;

   // register file; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= RST_PHASE_STEP;
         mod_depth_ff  <= RST_MOD_DEPTH;
         wave_shape_ff <= RST_WAVE_SHAPE;
         offset_ff     <= RST_OFFSET;
         min_gain_ff   <= RST_MIN_GAIN;
         wet_mix_ff    <= RST_WET_MIX;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PHASE_STEP:   phase_step_ff <= csr_data[23:0];
            REG_MOD_DEPTH:    mod_depth_ff  <= csr_data[15:0];
            REG_WAVE_SHAPE:   wave_shape_ff <= csr_data[2:0];
            REG_RIGHT_OFFSET: offset_ff     <= csr_data[15:0];
            REG_MIN_GAIN:     min_gain_ff   <= csr_data[15:0];
            REG_WET_MIX:      wet_mix_ff    <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // settings as used
   always_comb begin
      cfg.phase_step   = phase_step_ff;
      cfg.depth        = sat_q(mod_depth_ff);
      cfg.shape        = wave_shape_ff;
      cfg.phase_offset = offset_ff;
      cfg.floor_gain   = sat_q(min_gain_ff);
      cfg.mix          = sat_q(wet_mix_ff);
   end

endmodule

@@ rtl/stereo_tremolo_autopanner_core.sv @@
// -----------------------------------------------------------------------------
// Stereo tremolo / autopanner core
// Takes one stereo word per handshake and returns one processed word. A phase
// accumulator drives an LFO (sine, triangle, square, saw, reverse saw); the
// right channel reads it at a programmable phase lead. Each channel is scaled
// by min_gain + (1 - min_gain)(1 - depth + depth*lfo), blended with the dry
// sample by the wet mix, rounded and saturated. All products go through one
// registered 32x32 multiplier under a sequencer: a channel runs through index,
// depth, gain, weight, coefficient, multiply and round steps, and the sine
// shape adds six multiplies per channel for the table index and the
// quarter-wave polynomial, plus an index correction step and a table value
// step. An item is accepted in idle and, after both channels, loads the
// result register once any earlier result there has been taken; no new item
// is accepted before that. Input stall is high while an item is in
// progress; a finished word waits in the result register while the next
// item is accepted. Registers: 0 phase step, 1 depth, 2 wave shape, 3 right
// phase offset, 4 minimum gain, 5 wet mix; the user must write them only
// while the block is idle, and the block itself does not enforce it. The
// phase advances by the step after every item.
// -----------------------------------------------------------------------------
module stereo_tremolo_autopanner_core
   import stap_pkg::*;
#(
   parameter int PHASE_BITS       = PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam logic [MUL_W-1:0] DEPTH_OP = MUL_W'(SINE_TABLE_DEPTH);
   localparam logic [MUL_W-1:0] RECIP_OP = MUL_W'((64'd1 << 32) / SINE_TABLE_DEPTH);
   localparam logic [29:0] DEPTH_REM = 30'(SINE_TABLE_DEPTH);
   localparam logic signed [2*MUL_W-1:0] RND_HALF = (2*MUL_W)'(64'sd536870912);
   localparam logic signed [2*MUL_W-1:0] SAT_HI =
      ((2*MUL_W)'(64'sd1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [2*MUL_W-1:0] SAT_LO = -SAT_HI - 1;

   state_type state_ff, state_in;
   req_word_type word_ff, word_in;
   logic ch_ff, ch_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0] q_ff, q_in;
   logic [15:0] f_ff, f_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] x2_ff, x2_in;
   logic [15:0] lfo_ff, lfo_in;
   logic [1:0]  quad_ff, quad_in;
   logic [30:0] coef_ff, coef_in;
   logic signed [SAMPLE_BITS-1:0] res_l_ff, res_l_in, res_r_ff, res_r_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic rsp_valid_ff, rsp_valid_in;

   cfg_type cfg;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod;
   logic [15:0] p_ch;
   logic [15:0] wave_lfo;
   logic wave_sine;
   logic out_free;

   // intermediate values taken from the product register
   logic [IDX_W-1:0] idx_new;
   logic [15:0] q_new;
   logic [29:0] rem;
   logic [15:0] x_new;
   logic [15:0] x2_new;
   logic [15:0] t_val;
   logic [15:0] a_val;
   logic [16:0] s_raw, s_cl;
   logic [15:0] lfo_sine;
   logic [16:0] inner;
   logic [16:0] floor_rest;
   logic [15:0] gain;
   logic [30:0] coef_new;
   logic signed [SAMPLE_BITS-1:0] sample_sel;
   logic signed [2*MUL_W-1:0] rnd_sum, rnd_y;
   logic signed [SAMPLE_BITS-1:0] sample_sat;

   stap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   stap_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   stap_wave u_wave (
      .shape   (cfg.shape),
      .phase   (p_ch),
      .lfo     (wave_lfo),
      .is_sine (wave_sine)
   );

   // channel phase: right channel leads by the offset, wrapping
   assign p_ch = phase_ff[PHASE_BITS-1 -: 16] + (ch_ff ? cfg.phase_offset : 16'd0);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // arithmetic around the product register
   always_comb begin
      idx_new  = prod[16 +: IDX_W];
      q_new    = prod[31:16];
      rem      = 30'({idx_ff, 16'd0}) - prod[29:0];
      x_new    = f_ff[14] ? {15'(HALF_QUAD) - {1'b0, f_ff[13:0]}, 1'b0}
                          : {1'b0, f_ff[13:0], 1'b0};
      x2_new   = prod[30:15];
      t_val    = POLY_B - prod[30:15];
      a_val    = POLY_A - prod[30:15];
      s_raw    = prod[31:15];
      s_cl     = (s_raw > 17'(Q_ONE)) ? 17'(Q_ONE) : s_raw;
      lfo_sine = quad_ff[1] ? 16'((17'(Q_ONE) - s_cl) >> 1)
                            : 16'((17'(Q_ONE) + s_cl) >> 1);
      inner    = 17'(Q_ONE) - 17'(cfg.depth) + prod[31:15];
      floor_rest = 17'(Q_ONE) - 17'(cfg.floor_gain);
      gain     = 16'(17'(cfg.floor_gain) + prod[31:15]);
      coef_new = 31'({17'(Q_ONE) - 17'(cfg.mix), 15'd0}) + prod[30:0];
      sample_sel = ch_ff ? word_ff.right_in : word_ff.left_in;
      rnd_sum  = prod + RND_HALF;
      rnd_y    = rnd_sum >>> 30;
      if (rnd_y > SAT_HI) begin
         sample_sat = SAMPLE_BITS'(SAT_HI);
      end else if (rnd_y < SAT_LO) begin
         sample_sat = SAMPLE_BITS'(SAT_LO);
      end else begin
         sample_sat = rnd_y[SAMPLE_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_IDX;
         end
         ST_IDX:  state_in = wave_sine ? ST_QEST : ST_DL;
         ST_QEST: state_in = ST_QMUL;
         ST_QMUL: state_in = ST_QFIX;
         ST_QFIX: state_in = ST_X2;
         ST_X2:   state_in = ST_T;
         ST_T:    state_in = ST_A;
         ST_A:    state_in = ST_S;
         ST_S:    state_in = ST_LFO;
         ST_LFO:  state_in = ST_DL;
         ST_DL:   state_in = ST_MG;
         ST_MG:   state_in = ST_GW;
         ST_GW:   state_in = ST_COEF;
         ST_COEF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_RND;
         ST_RND:  state_in = ch_ff ? ST_OUT : ST_IDX;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and multiplier operand select
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDX: begin
            mul_a = MUL_W'(p_ch);
            mul_b = DEPTH_OP;
         end
         ST_QEST: begin
            mul_a = MUL_W'(idx_new);
            mul_b = RECIP_OP;
         end
         ST_QMUL: begin
            mul_a = MUL_W'(q_new);
            mul_b = DEPTH_OP;
         end
         ST_X2: begin
            mul_a = MUL_W'(x_new);
            mul_b = MUL_W'(x_new);
         end
         ST_T: begin
            mul_a = MUL_W'(x2_new);
            mul_b = MUL_W'(POLY_C);
         end
         ST_A: begin
            mul_a = MUL_W'(x2_ff);
            mul_b = MUL_W'(t_val);
         end
         ST_S: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(a_val);
         end
         ST_DL: begin
            mul_a = MUL_W'(cfg.depth);
            mul_b = MUL_W'(lfo_ff);
         end
         ST_MG: begin
            mul_a = MUL_W'(floor_rest);
            mul_b = MUL_W'(inner);
         end
         ST_GW: begin
            mul_a = MUL_W'(gain);
            mul_b = MUL_W'(cfg.mix);
         end
         ST_MUL: begin
            mul_a = MUL_W'(sample_sel);
            mul_b = MUL_W'(coef_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath register updates
   always_comb begin
      word_in      = word_ff;
      ch_in        = ch_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      f_in         = f_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      lfo_in       = lfo_ff;
      quad_in      = quad_ff;
      coef_in      = coef_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in = req_word;
               ch_in   = 1'b0;
            end
         end
         ST_IDX:  lfo_in = wave_lfo;
         ST_QEST: idx_in = idx_new;
         ST_QMUL: q_in = q_new;
         ST_QFIX: f_in = q_ff + 16'(rem >= DEPTH_REM);
         ST_X2: begin
            x_in    = x_new;
            quad_in = f_ff[15:14];
         end
         ST_T:    x2_in = x2_new;
         ST_LFO:  lfo_in = lfo_sine;
         ST_COEF: coef_in = coef_new;
         ST_RND: begin
            if (ch_ff) begin
               res_r_in = sample_sat;
            end else begin
               res_l_in = sample_sat;
            end
            ch_in = 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_word_in.left_out      = res_l_ff;
               rsp_word_in.right_out     = res_r_ff;
               rsp_word_in.block_end_out = word_ff.block_end_in;
               rsp_valid_in              = 1'b1;
               phase_in = phase_ff + PHASE_BITS'(cfg.phase_step);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      idx_ff      <= idx_in;
      q_ff        <= q_in;
      f_ff        <= f_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      lfo_ff      <= lfo_in;
      quad_ff     <= quad_in;
      coef_ff     <= coef_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/stap_checker.sv @@
// -----------------------------------------------------------------------------
// Tremolo / autopanner port checker
// Watches the request and response ports of the core; bound into the core module.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module stap_checker
   import stap_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a held result word keeps its value
   `STAP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // one item at a time: busy right after an accept
   `STAP_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "second word accepted while an item is in progress")

   // a new result only appears at the end of an item in progress
   `STAP_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "result appeared without an item in progress")

   // reset empties the result register
   `STAP_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind stereo_tremolo_autopanner_core stap_checker u_stap_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tremolo / autopanner core testbench
// Sends stereo words through the core and checks every returned word against
// a cycle-free predictor of the LFO, gain and mix arithmetic. The predictor
// keeps its own phase accumulator and register copy. Directed tests cover
// reset defaults, every wave shape (undefined codes included), gain extremes,
// out-of-range Q1.15 values and spare register indexes. A random part follows
// with changing settings under four idle/stall profiles.
// -----------------------------------------------------------------------------
module tb_top;
   import stap_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 20;
   localparam int WORDS_PER_PROFILE = 260;

   // spare register indexes, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // predictor state: raw register copy and LFO phase
   cfg_type      settings;
   logic [31:0]  phase_acc;
   rsp_word_type expected_words[$];

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   stereo_tremolo_autopanner_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] clamp_unity(input logic [15:0] v);
      return (v > Q_ONE) ? Q_ONE : v;
   endfunction

   // table entry from the quarter-wave polynomial, 1024-entry table
   function automatic logic [15:0] sine_lookup(input logic [9:0] idx);
      longint unsigned f, quad, u, x, x2, t, a, s;
      f = longint'(idx) * 64;
      quad = (f >> 14) & 3;
      u = f & 16'h3FFF;
      x = ((quad & 1) != 0 ? (16384 - u) : u) << 1;
      x2 = (x * x) >> 15;
      t = 21024 - ((x2 * 2320) >> 15);
      a = 51472 - ((x2 * t) >> 15);
      s = (x * a) >> 15;
      if (s > 32768) s = 32768;
      if (quad >= 2) return 16'((32768 - s) >> 1);
      return 16'((32768 + s) >> 1);
   endfunction

   function automatic logic [15:0] lfo_level(input logic [2:0] shape, input logic [31:0] phase);
      logic [15:0] p;
      p = phase[31:16];
      case (shape)
         WAVE_TRIANGLE: return (p < 16'd32768) ? p : 16'(17'd65536 - 17'(p));
         WAVE_SQUARE:   return (p < 16'd32768) ? Q_ONE : 16'd0;
         WAVE_SAW:      return p >> 1;
         WAVE_RSAW:     return Q_ONE - (p >> 1);
         default:       return sine_lookup(p[15:6]);
      endcase
   endfunction

   // gain, wet/dry blend, round half up, saturate
   function automatic logic [23:0] scale_channel(input logic signed [23:0] x,
                                                 input logic [15:0] lfo);
      longint d, m, w, inner, g, coef, prod, y;
      d = clamp_unity(settings.depth);
      m = clamp_unity(settings.floor_gain);
      w = clamp_unity(settings.mix);
      inner = 32768 - d + ((d * longint'(lfo)) >> 15);
      g = m + (((32768 - m) * inner) >> 15);
      coef = (32768 - w) * 32768 + g * w;
      prod = longint'(x) * coef + 64'sd536870912;
      y = prod >>> 30;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
   endfunction

   // expected word for one accepted pair; advances the phase
   function automatic rsp_word_type tremolo_pair(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  right_phase;
      right_phase = phase_acc + {settings.phase_offset, 16'h0000};
      r.left_out = scale_channel(w.left_in, lfo_level(settings.shape, phase_acc));
      r.right_out = scale_channel(w.right_in, lfo_level(settings.shape, right_phase));
      r.block_end_out = w.block_end_in;
      phase_acc = phase_acc + {8'h00, settings.phase_step};
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one stereo word, with an optional idle gap before it
   task automatic send_pair(input req_word_type w);
      int gap;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(40, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(tremolo_pair(w));
   endtask

   // leaves csr_valid high; callers drop it after the last write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PHASE_STEP:   settings.phase_step = data;
         REG_MOD_DEPTH:    settings.depth = data[15:0];
         REG_WAVE_SHAPE:   settings.shape = data[2:0];
         REG_RIGHT_OFFSET: settings.phase_offset = data[15:0];
         REG_MIN_GAIN:     settings.floor_gain = data[15:0];
         REG_WET_MIX:      settings.mix = data[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [23:0] step, input logic [23:0] depth,
                                 input logic [23:0] shape, input logic [23:0] offset,
                                 input logic [23:0] floor_gain, input logic [23:0] mix);
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_MOD_DEPTH, depth);
      write_reg(REG_WAVE_SHAPE, shape);
      write_reg(REG_RIGHT_OFFSET, offset);
      write_reg(REG_MIN_GAIN, floor_gain);
      write_reg(REG_WET_MIX, mix);
      csr_valid <= 1'b0;
   endtask

   // stop sending and let every outstanding word come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic req_word_type make_pair(input logic [23:0] l, input logic [23:0] r,
                                              input logic last);
      req_word_type w;
      w.left_in = l;
      w.right_in = r;
      w.block_end_in = last;
      return w;
   endfunction

   function automatic logic [23:0] pick_gain();
      case ($urandom_range(5))
         0:       return 24'd0;
         1:       return 24'(Q_ONE);
         2:       return 24'($urandom);
         default: return 24'($urandom_range(32768));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // register and phase values straight out of reset
   task automatic test_reset_defaults();
      send_pair(make_pair(24'h7FFFFF, 24'h800000, 1'b0));
      send_pair(make_pair(24'h800000, 24'h7FFFFF, 1'b1));
      send_pair(make_pair(24'h000000, 24'h000000, 1'b0));
      send_pair(make_pair(24'h000001, 24'hFFFFFF, 1'b1));
   endtask

   // every shape code, the undefined ones fall back to sine
   task automatic test_wave_shapes();
      wait_idle();
      apply_settings(24'hFFFFFF, 24'(Q_ONE), 24'(WAVE_SINE), 24'($urandom), 24'd0,
                     24'(Q_ONE));
      for (int s = 0; s < 8; s++) begin
         wait_idle();
         write_reg(REG_WAVE_SHAPE, CSR_DATA_BITS'(s));
         csr_valid <= 1'b0;
         send_pair(make_pair(s[0] ? 24'h7FFFFF : 24'h800000, 24'($urandom), s[1]));
      end
   endtask

   // gain corners, Q1.15 values above unity, spare indexes
   task automatic test_gain_extremes();
      wait_idle();
      // no modulation, widest right phase lead
      apply_settings(24'hFFFFFF, 24'd0, 24'(WAVE_TRIANGLE), 24'h00FFFF, 24'd0, 24'(Q_ONE));
      send_pair(make_pair(24'h7FFFFF, 24'h800000, 1'b1));
      wait_idle();
      // floor at unity
      apply_settings(24'hFFFFFF, 24'(Q_ONE), 24'(WAVE_SQUARE), 24'd0, 24'(Q_ONE),
                     24'(Q_ONE));
      send_pair(make_pair(24'h800000, 24'h7FFFFF, 1'b0));
      wait_idle();
      // fully dry
      apply_settings(24'd0, 24'(Q_ONE), 24'(WAVE_SAW), 24'd1, 24'd0, 24'd0);
      send_pair(make_pair(24'h7FFFFF, 24'h800000, 1'b1));
      wait_idle();
      // Q1.15 registers above unity saturate when used
      apply_settings(24'd1, 24'hFFFFFF, 24'(WAVE_RSAW), 24'hFFFFFF, 24'h008001, 24'hFFFFFF);
      send_pair(make_pair(24'h7FFFFF, 24'h800000, 1'b0));
      send_pair(make_pair(24'h123456, 24'hEDCBA9, 1'b1));
      wait_idle();
      write_reg(REG_SPARE_LO, 24'hFFFFFF);
      write_reg(REG_SPARE_HI, 24'd0);
      csr_valid <= 1'b0;
      send_pair(make_pair(24'h400000, 24'hC00000, 1'b0));
   endtask

   // random words in chunks, fresh settings per chunk, four pressure profiles
   task automatic test_random_traffic();
      int           sent;
      int           chunk;
      logic [23:0]  step;
      logic [23:0]  shape;
      logic [23:0]  offset;
      req_word_type w;
      for (int profile = 0; profile < 4; profile++) begin
         case (profile)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         sent = 0;
         while (sent < WORDS_PER_PROFILE) begin
            wait_idle();
            case ($urandom_range(4))
               0:       step = 24'd0;
               1:       step = 24'hFFFFFF;
               2:       step = 24'($urandom_range(4096));
               default: step = 24'($urandom);
            endcase
            shape = ($urandom_range(9) < 8) ? 24'($urandom_range(4))
                                            : 24'($urandom_range(7, 5));
            case ($urandom_range(5))
               0:       offset = 24'd0;
               1:       offset = 24'h00FFFF;
               default: offset = 24'($urandom);
            endcase
            apply_settings(step, pick_gain(), shape, offset, pick_gain(), pick_gain());
            chunk = $urandom_range(60, 20);
            repeat (chunk) begin
               w.left_in = 24'($urandom);
               w.right_in = 24'($urandom);
               w.block_end_in = 1'($urandom_range(1));
               send_pair(w);
            end
            sent += chunk;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // compare each taken word with the oldest expected one
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.left_out !== want.left_out) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: left_out expected %h actual %h", $time,
                           want.left_out, rsp_word.left_out);
            end
            if (rsp_word.right_out !== want.right_out) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: right_out expected %h actual %h", $time,
                           want.right_out, rsp_word.right_out);
            end
            if (rsp_word.block_end_out !== want.block_end_out) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: block_end_out expected %b actual %b", $time,
                           want.block_end_out, rsp_word.block_end_out);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      settings.phase_step = RST_PHASE_STEP;
      settings.depth = RST_MOD_DEPTH;
      settings.shape = RST_WAVE_SHAPE;
      settings.phase_offset = RST_OFFSET;
      settings.floor_gain = RST_MIN_GAIN;
      settings.mix = RST_WET_MIX;
      phase_acc = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      send_idle_pct = 16;
      recv_stall_pct = 16;
      test_reset_defaults();
      test_wave_shapes();
      test_gain_extremes();
      test_random_traffic();
      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/stap_pkg.sv
rtl/stap_mul.sv
rtl/stap_wave.sv
rtl/stap_csr.sv
rtl/stereo_tremolo_autopanner_core.sv
rtl/stap_checker.sv
tb/sv/tb_top.sv
